/* hdl/gcpr_pkg.sv */
// Shared types and constants for the gimbal cascade PI and rate limiter.
// Depends on nothing; used by every module of the block.
package gcpr_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 30;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // stream payload widths
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 40;

    // parameter defaults
    localparam int CURRENT_LIMIT_DEF    = 16384;
    localparam int PITCH_SLEW_LIMIT_DEF = 327680;
    localparam int PITCH_FF_GAIN_DEF    = 65536;

    // parameter ranges
    localparam int CUR_ABS_MAX = 16384;
    localparam int SLEW_MIN    = 6554;
    localparam int SLEW_MAX    = 1310720;

    // fixed-point constants
    localparam logic signed [19:0] Q_PI        = 20'sd205887;
    localparam logic signed [19:0] Q_TWO_PI    = 20'sd411774;
    localparam logic signed [21:0] POS_INT_MAX  = 22'sd327680;
    localparam logic signed [28:0] RATE_INT_MAX = 29'sd117964800;
    localparam logic [25:0] POS_GAIN_MAX  = 26'd65536000;
    localparam logic [31:0] RATE_GAIN_MAX = 32'd3276800000;
    localparam logic [21:0] YAW_RATE_MIN  = 22'd6554;
    localparam logic [21:0] YAW_RATE_CEIL = 22'd3932160;

    typedef struct packed {
        logic [25:0]        pos_gain_p;
        logic [25:0]        pos_gain_i;
        logic [31:0]        rate_gain_p;
        logic [31:0]        rate_gain_i;
        logic signed [23:0] yaw_ff_gain;
        logic [21:0]        yaw_rate_limit;
        logic signed [18:0] pitch_upper;
        logic signed [18:0] pitch_lower;
    } gcpr_cfg_t;

    typedef struct packed {
        logic [15:0]        step_time;
        logic signed [18:0] yaw_target;
        logic signed [18:0] yaw_angle;
        logic signed [23:0] yaw_gyro;
        logic signed [23:0] yaw_target_speed;
        logic signed [18:0] pitch_target;
        logic signed [23:0] pitch_target_speed;
        logic signed [18:0] pitch_feedback;
    } gcpr_item_t;

endpackage

/* hdl/gcpr_cfg.sv */
// Configuration register file behind an APB-style port.
// Depends on gcpr_pkg.
module gcpr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gcpr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [gcpr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [gcpr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output gcpr_pkg::gcpr_cfg_t              cfg
);
    import gcpr_pkg::*;

    typedef enum logic [2:0] {
        REG_POS_GAIN_P   = 3'd0,
        REG_POS_GAIN_I   = 3'd1,
        REG_RATE_GAIN_P  = 3'd2,
        REG_RATE_GAIN_I  = 3'd3,
        REG_YAW_FF_GAIN  = 3'd4,
        REG_YAW_RATE_LIM = 3'd5,
        REG_PITCH_UPPER  = 3'd6,
        REG_PITCH_LOWER  = 3'd7
    } gcpr_reg_t;

    gcpr_cfg_t cfg_reg;
    gcpr_reg_t reg_idx;
    logic      wr_en;

    assign reg_idx = gcpr_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                <= '0;
            cfg_reg.yaw_rate_limit <= YAW_RATE_MIN;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_POS_GAIN_P:   cfg_reg.pos_gain_p     <= pwdata[25:0];
                REG_POS_GAIN_I:   cfg_reg.pos_gain_i     <= pwdata[25:0];
                REG_RATE_GAIN_P:  cfg_reg.rate_gain_p    <= pwdata[31:0];
                REG_RATE_GAIN_I:  cfg_reg.rate_gain_i    <= pwdata[31:0];
                REG_YAW_FF_GAIN:  cfg_reg.yaw_ff_gain    <= $signed(pwdata[23:0]);
                REG_YAW_RATE_LIM: cfg_reg.yaw_rate_limit <= pwdata[21:0];
                REG_PITCH_UPPER:  cfg_reg.pitch_upper    <= $signed(pwdata[18:0]);
                REG_PITCH_LOWER:  cfg_reg.pitch_lower    <= $signed(pwdata[18:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POS_GAIN_P:   prdata = {6'd0, cfg_reg.pos_gain_p};
            REG_POS_GAIN_I:   prdata = {6'd0, cfg_reg.pos_gain_i};
            REG_RATE_GAIN_P:  prdata = cfg_reg.rate_gain_p;
            REG_RATE_GAIN_I:  prdata = cfg_reg.rate_gain_i;
            REG_YAW_FF_GAIN:  prdata = {8'd0, cfg_reg.yaw_ff_gain};
            REG_YAW_RATE_LIM: prdata = {10'd0, cfg_reg.yaw_rate_limit};
            REG_PITCH_UPPER:  prdata = {13'd0, cfg_reg.pitch_upper};
            REG_PITCH_LOWER:  prdata = {13'd0, cfg_reg.pitch_lower};
            default:          prdata = '0;
        endcase
    end

endmodule

/* hdl/gcpr_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on gcpr_pkg.
module gcpr_mul (
    input  logic                                clk,
    input  logic signed [gcpr_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [gcpr_pkg::MUL_B_W-1:0] op_b,
    output logic signed [gcpr_pkg::PROD_W-1:0]  prod
);
    import gcpr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* hdl/gcpr_core.sv */
// Sequencer and datapath: yaw cascade PI and pitch slew limiter, all
// products formed one per cycle on the shared multiplier. Depends on gcpr_pkg, gcpr_mul.
module gcpr_core #(
    parameter int CURRENT_LIMIT    = gcpr_pkg::CURRENT_LIMIT_DEF,
    parameter int PITCH_SLEW_LIMIT = gcpr_pkg::PITCH_SLEW_LIMIT_DEF,
    parameter int PITCH_FF_GAIN    = gcpr_pkg::PITCH_FF_GAIN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcpr_pkg::gcpr_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_func,
    input  gcpr_pkg::gcpr_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   out_yaw_current,
    output logic signed [18:0]   out_pitch_reference
);
    import gcpr_pkg::*;

    localparam int CUR_MAX_I = (CURRENT_LIMIT < 0) ? 0 :
                               (CURRENT_LIMIT > CUR_ABS_MAX) ? CUR_ABS_MAX : CURRENT_LIMIT;
    localparam int SLEW_I    = (PITCH_SLEW_LIMIT < SLEW_MIN) ? SLEW_MIN :
                               (PITCH_SLEW_LIMIT > SLEW_MAX) ? SLEW_MAX : PITCH_SLEW_LIMIT;
    localparam logic signed [31:0]        CUR_HI = 32'(CUR_MAX_I);
    localparam logic signed [MUL_A_W-1:0] SLEW_C = MUL_A_W'(SLEW_I);
    localparam logic signed [MUL_A_W-1:0] FFG_C  = MUL_A_W'(PITCH_FF_GAIN);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_ERR  = 15'b000000000000010,
        ST_M1   = 15'b000000000000100,
        ST_PI   = 15'b000000000001000,
        ST_A0   = 15'b000000000010000,
        ST_A1   = 15'b000000000100000,
        ST_A2   = 15'b000000001000000,
        ST_A3   = 15'b000000010000000,
        ST_RR   = 15'b000000100000000,
        ST_RE   = 15'b000001000000000,
        ST_M2   = 15'b000010000000000,
        ST_RI   = 15'b000100000000000,
        ST_B1   = 15'b001000000000000,
        ST_B2   = 15'b010000000000000,
        ST_FIN  = 15'b100000000000000
    } gcpr_state_t;

    gcpr_state_t state_reg, state_next;

    // persistent state
    logic               yaw_started_reg, pitch_started_reg;
    logic signed [19:0] pos_int_reg;
    logic signed [27:0] rate_int_reg;
    logic signed [18:0] held_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_cur_reg;
    logic signed [18:0] out_ref_reg;

    // per-word working registers
    gcpr_item_t         item_reg;
    logic signed [18:0] err_reg;
    logic signed [29:0] ff_reg;
    logic signed [19:0] pint_reg;
    logic signed [29:0] pstep_reg;
    logic signed [63:0] acc_reg;
    logic signed [22:0] rref_reg;
    logic signed [21:0] stepmax_reg;
    logic signed [24:0] rerr_reg;
    logic signed [31:0] perr_reg;
    logic signed [27:0] rint_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic accept, fin_go;
    logic signed [MUL_B_W-1:0] dt_b;
    logic [25:0] kp1, ki1;
    logic [31:0] kp2, ki2;
    logic [21:0] lim;
    logic signed [19:0] ydiff, ywrap;
    logic signed [21:0] pint_sum;
    logic signed [19:0] pint_sat;
    logic signed [47:0] rsh, lim_s;
    logic signed [22:0] rref_sat;
    logic signed [28:0] rint_sum;
    logic signed [27:0] rint_sat;
    logic signed [31:0] csh;
    logic signed [15:0] cur_sat;
    logic signed [31:0] smax_s, pmove;
    logic signed [22:0] held_sum;
    logic signed [18:0] held_new, tgt_c, fb_c;

    function automatic logic signed [18:0] clamp_pitch(
        input logic signed [22:0] v,
        input logic signed [18:0] lo,
        input logic signed [18:0] hi
    );
        logic signed [18:0] r;
        if (v < 23'(lo))
            r = lo;
        else if (v > 23'(hi))
            r = hi;
        else
            r = v[18:0];
        return r;
    endfunction

    gcpr_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign fin_go   = (state_reg == ST_FIN) & (~out_valid_reg | out_ready);

    assign out_valid           = out_valid_reg;
    assign out_yaw_current     = out_cur_reg;
    assign out_pitch_reference = out_ref_reg;

    assign dt_b = $signed({14'd0, item_reg.step_time});

    // saturate gains and limits into their ranges
    assign kp1 = (cfg.pos_gain_p > POS_GAIN_MAX) ? POS_GAIN_MAX : cfg.pos_gain_p;
    assign ki1 = (cfg.pos_gain_i > POS_GAIN_MAX) ? POS_GAIN_MAX : cfg.pos_gain_i;
    assign kp2 = (cfg.rate_gain_p > RATE_GAIN_MAX) ? RATE_GAIN_MAX : cfg.rate_gain_p;
    assign ki2 = (cfg.rate_gain_i > RATE_GAIN_MAX) ? RATE_GAIN_MAX : cfg.rate_gain_i;
    assign lim = (cfg.yaw_rate_limit < YAW_RATE_MIN) ? YAW_RATE_MIN :
                 (cfg.yaw_rate_limit > YAW_RATE_CEIL) ? YAW_RATE_CEIL : cfg.yaw_rate_limit;

    // angle error wrapped into (-pi, pi]; one correction covers all inputs
    assign ydiff = 20'($signed(item_reg.yaw_target)) - 20'($signed(item_reg.yaw_angle));
    always_comb
    begin
        if (ydiff > Q_PI)
            ywrap = ydiff - Q_TWO_PI;
        else if (ydiff <= -Q_PI)
            ywrap = ydiff + Q_TWO_PI;
        else
            ywrap = ydiff;
    end

    // position integral: prod holds err*dt
    assign pint_sum = 22'(pos_int_reg) + 22'($signed(prod[34:16]));
    always_comb
    begin
        if (pint_sum < -POS_INT_MAX)
            pint_sat = 20'(-POS_INT_MAX);
        else if (pint_sum > POS_INT_MAX)
            pint_sat = 20'(POS_INT_MAX);
        else
            pint_sat = pint_sum[19:0];
    end

    // rate reference
    assign rsh   = acc_reg[63:16];
    assign lim_s = $signed({26'd0, lim});
    always_comb
    begin
        if (rsh < -lim_s)
            rref_sat = 23'(-lim_s);
        else if (rsh > lim_s)
            rref_sat = 23'(lim_s);
        else
            rref_sat = rsh[22:0];
    end

    // rate integral: prod holds rate_err*dt
    assign rint_sum = 29'(rate_int_reg) + 29'($signed(prod[40:16]));
    always_comb
    begin
        if (rint_sum < -RATE_INT_MAX)
            rint_sat = 28'(-RATE_INT_MAX);
        else if (rint_sum > RATE_INT_MAX)
            rint_sat = 28'(RATE_INT_MAX);
        else
            rint_sat = rint_sum[27:0];
    end

    // motor current
    assign csh = acc_reg[63:32];
    always_comb
    begin
        if (csh < -CUR_HI)
            cur_sat = 16'(-CUR_HI);
        else if (csh > CUR_HI)
            cur_sat = 16'(CUR_HI);
        else
            cur_sat = csh[15:0];
    end

    // pitch slew limit
    assign smax_s = 32'(stepmax_reg);
    always_comb
    begin
        if (perr_reg < -smax_s)
            pmove = -smax_s;
        else if (perr_reg > smax_s)
            pmove = smax_s;
        else
            pmove = perr_reg;
    end
    assign held_sum = 23'(held_reg) + 23'($signed(pmove[21:0]));
    assign held_new = clamp_pitch(held_sum, cfg.pitch_lower, cfg.pitch_upper);
    assign tgt_c    = clamp_pitch(23'($signed(item_reg.pitch_target)),
                                  cfg.pitch_lower, cfg.pitch_upper);
    assign fb_c     = clamp_pitch(23'($signed(in_item.pitch_feedback)),
                                  cfg.pitch_lower, cfg.pitch_upper);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ERR:
            begin
                mul_a = FFG_C;
                mul_b = MUL_B_W'($signed(item_reg.pitch_target_speed));
            end
            ST_M1:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = dt_b;
            end
            ST_PI:
            begin
                mul_a = MUL_A_W'(ff_reg);
                mul_b = dt_b;
            end
            ST_A0:
            begin
                mul_a = $signed({7'd0, kp1});
                mul_b = MUL_B_W'(err_reg);
            end
            ST_A1:
            begin
                mul_a = $signed({7'd0, ki1});
                mul_b = MUL_B_W'(pint_reg);
            end
            ST_A2:
            begin
                mul_a = MUL_A_W'($signed(cfg.yaw_ff_gain));
                mul_b = MUL_B_W'($signed(item_reg.yaw_target_speed));
            end
            ST_A3:
            begin
                mul_a = SLEW_C;
                mul_b = dt_b;
            end
            ST_M2:
            begin
                mul_a = MUL_A_W'(rerr_reg);
                mul_b = dt_b;
            end
            ST_RI:
            begin
                mul_a = $signed({1'b0, kp2});
                mul_b = MUL_B_W'(rerr_reg);
            end
            ST_B1:
            begin
                mul_a = $signed({1'b0, ki2});
                mul_b = MUL_B_W'(rint_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && !in_func) state_next = ST_ERR;
            ST_ERR:  state_next = ST_M1;
            ST_M1:   state_next = ST_PI;
            ST_PI:   state_next = ST_A0;
            ST_A0:   state_next = ST_A1;
            ST_A1:   state_next = ST_A2;
            ST_A2:   state_next = ST_A3;
            ST_A3:   state_next = ST_RR;
            ST_RR:   state_next = ST_RE;
            ST_RE:   state_next = ST_M2;
            ST_M2:   state_next = ST_RI;
            ST_RI:   state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            yaw_started_reg   <= 1'b0;
            pitch_started_reg <= 1'b0;
            pos_int_reg       <= '0;
            rate_int_reg      <= '0;
            held_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && in_func)
            begin
                yaw_started_reg   <= 1'b0;
                pitch_started_reg <= 1'b0;
                pos_int_reg       <= '0;
                rate_int_reg      <= '0;
                held_reg          <= fb_c;
            end
            if (fin_go)
            begin
                yaw_started_reg   <= 1'b1;
                pitch_started_reg <= 1'b1;
                if (yaw_started_reg)
                begin
                    pos_int_reg  <= pint_reg;
                    rate_int_reg <= rint_reg;
                end
                if (pitch_started_reg)
                    held_reg <= held_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        if (fin_go)
        begin
            out_cur_reg <= yaw_started_reg ? cur_sat : 16'sd0;
            out_ref_reg <= pitch_started_reg ? held_new : held_reg;
        end
        case (state_reg)
            ST_ERR: err_reg   <= ywrap[18:0];
            ST_M1:  ff_reg    <= prod[45:16];
            ST_PI:  pint_reg  <= pint_sat;
            ST_A0:  pstep_reg <= prod[45:16];
            ST_A1:  acc_reg   <= 64'(prod);
            ST_A2:  acc_reg   <= acc_reg + 64'(prod);
            ST_A3:  acc_reg   <= acc_reg + 64'(prod);
            ST_RR:
            begin
                rref_reg    <= rref_sat;
                stepmax_reg <= prod[37:16];
            end
            ST_RE:
            begin
                rerr_reg <= 25'(rref_reg) - 25'($signed(item_reg.yaw_gyro));
                perr_reg <= 32'(tgt_c) - 32'(held_reg) + 32'(pstep_reg);
            end
            ST_RI:  rint_reg  <= rint_sat;
            ST_B1:  acc_reg   <= 64'(prod);
            ST_B2:  acc_reg   <= acc_reg + 64'(prod);
            default:
            begin
            end
        endcase
    end

endmodule

/* hdl/gimbal_cascade_pi_and_rate_limiter.sv */
// Gimbal yaw cascade PI and pitch slew limiter, top level.
// Control word: accepted only when idle; the result is registered when the
// 14-step sequence on the single shared 33x30 multiplier completes.
// Reset word: taken when idle, no result. A waiting result does not block input.
// rst_n (async, active low) resets state, integrals, start flags, pitch hold, config.
// Depends on gcpr_pkg, gcpr_cfg, gcpr_core.
module gimbal_cascade_pi_and_rate_limiter #(
    parameter int CURRENT_LIMIT    = gcpr_pkg::CURRENT_LIMIT_DEF,
    parameter int PITCH_SLEW_LIMIT = gcpr_pkg::PITCH_SLEW_LIMIT_DEF,
    parameter int PITCH_FF_GAIN    = gcpr_pkg::PITCH_FF_GAIN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // step_time, yaw_target, yaw_angle, yaw_gyro, yaw_target_speed,
    // pitch_target, pitch_target_speed, pitch_feedback, zero pad
    input  logic [gcpr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // yaw_current, pitch_reference, zero pad
    output logic [gcpr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gcpr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gcpr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gcpr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import gcpr_pkg::*;

    gcpr_cfg_t          cfg;
    gcpr_item_t         item;
    logic signed [15:0] yaw_current;
    logic signed [18:0] pitch_reference;

    assign item.step_time          = s_axis_tdata[15:0];
    assign item.yaw_target         = $signed(s_axis_tdata[34:16]);
    assign item.yaw_angle          = $signed(s_axis_tdata[53:35]);
    assign item.yaw_gyro           = $signed(s_axis_tdata[77:54]);
    assign item.yaw_target_speed   = $signed(s_axis_tdata[101:78]);
    assign item.pitch_target       = $signed(s_axis_tdata[120:102]);
    assign item.pitch_target_speed = $signed(s_axis_tdata[144:121]);
    assign item.pitch_feedback     = $signed(s_axis_tdata[163:145]);

    assign m_axis_tdata = {5'd0, pitch_reference, yaw_current};

    gcpr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gcpr_core #(
        .CURRENT_LIMIT    (CURRENT_LIMIT),
        .PITCH_SLEW_LIMIT (PITCH_SLEW_LIMIT),
        .PITCH_FF_GAIN    (PITCH_FF_GAIN)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .in_valid            (s_axis_tvalid),
        .in_ready            (s_axis_tready),
        .in_func             (s_axis_tuser[0]),
        .in_item             (item),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .out_yaw_current     (yaw_current),
        .out_pitch_reference (pitch_reference)
    );

endmodule
